// ===== rtl/assert_macros.svh =====
// assertion macros used by the checker file sdf_checker.sv
// no dependencies; clock and reset names follow the project port convention
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property sampled on clk_i, switched off while rst_ni is low
`define SDF_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// expression that must never be true out of reset
`define SDF_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(expr)) else $error(msg);

`endif

// ===== rtl/sdf_pkg.sv =====
// types and constants of the signed decimal formatter
// used by the digit cells, the digit row and the top level
package sdf_pkg;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_CLEAR,
    OP_DABBLE,
    OP_SHIFT
  } cell_op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CONV,
    ST_NORM,
    ST_SIZE,
    ST_EMIT
  } state_e;

  // option bit positions
  localparam int unsigned OPT_LEFT_JUST  = 0;
  localparam int unsigned OPT_ZERO_PAD   = 1;
  localparam int unsigned OPT_PLUS_SIGN  = 2;
  localparam int unsigned OPT_SPACE_SIGN = 3;

  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_PLUS  = 8'h2B;
  localparam logic [7:0] CHAR_MINUS = 8'h2D;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;

  // shift-and-add-3 correction
  localparam logic [3:0] DABBLE_MIN = 4'd5;
  localparam logic [3:0] DABBLE_ADD = 4'd3;

endpackage

// ===== rtl/sdf_bcd_cell.sv =====
// one decimal digit cell: binary to bcd step, digit shift toward the top
// depends on sdf_pkg
module sdf_bcd_cell (
  input  logic             clk_i,
  input  sdf_pkg::cell_op_e op_i,
  input  logic             bit_i,
  input  logic [3:0]       dig_i,
  output logic             bit_o,
  output logic [3:0]       dig_o
);

  logic [3:0] digit_q, digit_d;
  logic [3:0] adj;

  always_comb begin
    adj = (digit_q >= sdf_pkg::DABBLE_MIN) ? digit_q + sdf_pkg::DABBLE_ADD : digit_q;
    case (op_i)
      sdf_pkg::OP_CLEAR:  digit_d = '0;
      sdf_pkg::OP_DABBLE: digit_d = {adj[2:0], bit_i};
      sdf_pkg::OP_SHIFT:  digit_d = dig_i;
      default:            digit_d = digit_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    digit_q <= digit_d;
  end

  assign bit_o = adj[3];
  assign dig_o = digit_q;

endmodule

// ===== rtl/sdf_digit_row.sv =====
// row of bcd cells, least significant at index 0
// depends on sdf_pkg and sdf_bcd_cell
module sdf_digit_row #(
  parameter int unsigned NUM_DIGITS = 20
) (
  input  logic              clk_i,
  input  sdf_pkg::cell_op_e op_i,
  input  logic              bit_i,
  output logic [3:0]        top_o
);

  logic [NUM_DIGITS-1:0] carry;
  logic [3:0]            dig [NUM_DIGITS];

  for (genvar i = 0; i < NUM_DIGITS; i++) begin : g_cell
    logic       cin;
    logic [3:0] din;
    if (i == 0) begin : g_first
      assign cin = bit_i;
      assign din = '0;
    end else begin : g_next
      assign cin = carry[i-1];
      assign din = dig[i-1];
    end
    sdf_bcd_cell u_cell (
      .clk_i (clk_i),
      .op_i  (op_i),
      .bit_i (cin),
      .dig_i (din),
      .bit_o (carry[i]),
      .dig_o (dig[i])
    );
  end

  assign top_o = dig[NUM_DIGITS-1];

endmodule

// ===== rtl/signed_decimal_formatter_core.sv =====
// Signed decimal formatter (printf %d). One input beat carries a value and its
// options; the output channel returns the field one character per beat, last_o
// on the final one. If the field plus terminator exceeds room_i a single beat
// with character_o = 0, last_o = 1 and no_room_o = 1 is sent instead.
// Both channels are valid/ready. An item is taken only in idle; the next one is
// taken as soon as the final character sits in the output register.
// Steps per item: accept, shift-and-add-3 over every value bit in the digit
// row, normalizing (stripping leading zeros, then a final check), sizing,
// then one character per cycle while the receiver takes them. With the
// default parameters the field is 1 to 64 characters long. The digit
// conversion over the row of cells is the longest step before emission.
// A stall on out_ready_i holds the output register and pauses emission.
// Reset returns to idle and empties the output register; nothing is kept
// between items.
// Depends on sdf_pkg, sdf_digit_row, sdf_bcd_cell.
module signed_decimal_formatter_core #(
  parameter int unsigned MAX_FIELD  = 63,
  parameter int unsigned VALUE_BITS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [63:0] value_i,
  input  logic [5:0]  field_width_i,
  input  logic        has_precision_i,
  input  logic [5:0]  min_digits_i,
  input  logic [3:0]  flag_bits_i,
  input  logic [7:0]  room_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  output logic [7:0]  character_o,
  output logic        last_o,
  output logic        no_room_o,
  output logic        out_valid_o,
  input  logic        out_ready_i
);

  localparam int unsigned NumDigits = (VALUE_BITS * 301) / 1000 + 1;
  localparam int unsigned NdW       = $clog2(NumDigits + 1);
  localparam int unsigned CntW      = $clog2(VALUE_BITS);
  localparam logic [5:0]  MaxField  = 6'(MAX_FIELD);

  sdf_pkg::state_e   state_q, state_d;
  sdf_pkg::cell_op_e row_op;
  logic              row_bit;
  logic [3:0]        top_dig;

  logic [VALUE_BITS-1:0] mag_q, mag_in, v_in;
  logic [CntW-1:0]       cnt_q;
  logic [NdW-1:0]        nd_q;
  logic                  neg_q;
  logic [5:0]            fw_q, md_q;
  logic                  hp_q;
  logic [3:0]            flags_q;
  logic [7:0]            room_q;
  logic [6:0]            pos_q, lead_q, bzero_q, bdig_q, bdone_q, total_q;
  logic                  err_q;

  logic       out_valid_q, last_q, no_room_q;
  logic [7:0] char_q;

  logic in_accept, can_load, emit, strip;

  // sizing results
  logic [5:0] w_sat, p_sat;
  logic       sign_len;
  logic [6:0] nd7, ndig, nlen, total, lead, wm, bzero, bdig, bdone;
  logic       err;

  // emission selection
  logic [7:0] next_char, sign_char;
  logic       next_last, digit_out;

  assign v_in      = value_i[VALUE_BITS-1:0];
  assign mag_in    = v_in[VALUE_BITS-1] ? VALUE_BITS'(~v_in + 1'b1) : v_in;
  assign in_accept = in_valid_i && in_ready_o;
  assign can_load  = !out_valid_q || out_ready_i;
  assign strip     = (top_dig == 4'd0) && (nd_q > NdW'(1));

  sdf_digit_row #(
    .NUM_DIGITS (NumDigits)
  ) u_row (
    .clk_i (clk_i),
    .op_i  (row_op),
    .bit_i (row_bit),
    .top_o (top_dig)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      sdf_pkg::ST_IDLE: if (in_valid_i) state_d = sdf_pkg::ST_CONV;
      sdf_pkg::ST_CONV: if (cnt_q == '0) state_d = sdf_pkg::ST_NORM;
      sdf_pkg::ST_NORM: if (!strip) state_d = sdf_pkg::ST_SIZE;
      sdf_pkg::ST_SIZE: state_d = sdf_pkg::ST_EMIT;
      sdf_pkg::ST_EMIT: if (can_load && (err_q || next_last)) state_d = sdf_pkg::ST_IDLE;
      default:          state_d = sdf_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_ready_o = 1'b0;
    row_op     = sdf_pkg::OP_HOLD;
    row_bit    = mag_q[VALUE_BITS-1];
    emit       = 1'b0;
    case (state_q)
      sdf_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) row_op = sdf_pkg::OP_CLEAR;
      end
      sdf_pkg::ST_CONV: row_op = sdf_pkg::OP_DABBLE;
      sdf_pkg::ST_NORM: if (strip) row_op = sdf_pkg::OP_SHIFT;
      sdf_pkg::ST_EMIT: begin
        emit = can_load;
        if (can_load && digit_out && !err_q) row_op = sdf_pkg::OP_SHIFT;
      end
      default: row_op = sdf_pkg::OP_HOLD;
    endcase
  end

  // field layout, worked out once the digit count is known
  always_comb begin
    w_sat    = (fw_q > MaxField) ? MaxField : fw_q;
    p_sat    = (md_q > MaxField) ? MaxField : md_q;
    sign_len = neg_q | flags_q[sdf_pkg::OPT_PLUS_SIGN] | flags_q[sdf_pkg::OPT_SPACE_SIGN];
    nd7      = 7'(nd_q);
    wm       = {1'b0, w_sat} - {6'b0, sign_len};
    ndig     = nd7;
    if (hp_q) begin
      if ({1'b0, p_sat} > nd7) ndig = {1'b0, p_sat};
    end else if (flags_q[sdf_pkg::OPT_ZERO_PAD] && !flags_q[sdf_pkg::OPT_LEFT_JUST]) begin
      // zero fill counts the sign inside the width
      if (({1'b0, w_sat} > {6'b0, sign_len}) && (wm > nd7)) ndig = wm;
    end
    nlen  = {6'b0, sign_len} + ndig;
    total = ({1'b0, w_sat} > nlen) ? {1'b0, w_sat} : nlen;
    lead  = flags_q[sdf_pkg::OPT_LEFT_JUST] ? 7'd0 : total - nlen;
    bzero = lead + {6'b0, sign_len};
    bdig  = bzero + (ndig - nd7);
    bdone = bdig + nd7;
    err   = (({1'b0, total} + 8'd1) > room_q) || (total == 7'd0);
  end

  // character at the current position
  always_comb begin
    if (neg_q) begin
      sign_char = sdf_pkg::CHAR_MINUS;
    end else if (flags_q[sdf_pkg::OPT_PLUS_SIGN]) begin
      sign_char = sdf_pkg::CHAR_PLUS;
    end else begin
      sign_char = sdf_pkg::CHAR_SPACE;
    end
    digit_out = 1'b0;
    if (pos_q < lead_q) begin
      next_char = sdf_pkg::CHAR_SPACE;
    end else if (pos_q < bzero_q) begin
      next_char = sign_char;
    end else if (pos_q < bdig_q) begin
      next_char = sdf_pkg::CHAR_ZERO;
    end else if (pos_q < bdone_q) begin
      next_char = sdf_pkg::CHAR_ZERO + {4'b0, top_dig};
      digit_out = 1'b1;
    end else begin
      next_char = sdf_pkg::CHAR_SPACE;
    end
    next_last = (pos_q == total_q - 7'd1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sdf_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      mag_q   <= mag_in;
      neg_q   <= v_in[VALUE_BITS-1];
      cnt_q   <= CntW'(VALUE_BITS - 1);
      nd_q    <= NdW'(NumDigits);
      fw_q    <= field_width_i;
      hp_q    <= has_precision_i;
      md_q    <= min_digits_i;
      flags_q <= flag_bits_i;
      room_q  <= room_i;
    end
    if (state_q == sdf_pkg::ST_CONV) begin
      mag_q <= {mag_q[VALUE_BITS-2:0], 1'b0};
      cnt_q <= cnt_q - 1'b1;
    end
    if ((state_q == sdf_pkg::ST_NORM) && strip) begin
      nd_q <= nd_q - 1'b1;
    end
    if (state_q == sdf_pkg::ST_SIZE) begin
      lead_q  <= lead;
      bzero_q <= bzero;
      bdig_q  <= bdig;
      bdone_q <= bdone;
      total_q <= total;
      err_q   <= err;
      pos_q   <= '0;
    end
    if (emit) begin
      pos_q     <= pos_q + 7'd1;
      char_q    <= err_q ? sdf_pkg::CHAR_NUL : next_char;
      last_q    <= err_q | next_last;
      no_room_q <= err_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign character_o = char_q;
  assign last_o      = last_q;
  assign no_room_o   = no_room_q;

endmodule

// ===== rtl/sdf_checker.sv =====
// port-level checks for signed_decimal_formatter_core, attached by bind
// depends on assert_macros.svh and sdf_pkg
`include "assert_macros.svh"

module sdf_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_o,
  input logic [7:0]  character_o,
  input logic        last_o,
  input logic        no_room_o,
  input logic        out_valid_o,
  input logic        out_ready_i
);

  // an error beat is a lone nul that closes the item
  `SDF_ASSERT(a_err_beat, out_valid_o && no_room_o |-> last_o && character_o == sdf_pkg::CHAR_NUL, "error beat malformed")

  // a stalled beat keeps its content
  `SDF_ASSERT(a_out_hold, out_valid_o && !out_ready_i |=> out_valid_o && $stable(character_o) && $stable(last_o), "stalled beat changed")

  // taking an item closes the input until the item is worked off
  `SDF_ASSERT(a_in_busy, in_valid_i && in_ready_o |=> !in_ready_o, "second item taken while busy")

  // a beat that is not the last means the item is still being emitted
  `SDF_NEVER(a_mid_ready, out_valid_o && !last_o && in_ready_o, "input open mid-field")

endmodule

bind signed_decimal_formatter_core sdf_checker u_sdf_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_ready_o  (in_ready_o),
  .character_o (character_o),
  .last_o      (last_o),
  .no_room_o   (no_room_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i)
);

// ===== test/signed_decimal_formatter_core_tb.sv =====
// testbench for signed_decimal_formatter_core: printf %d fields, one character per beat
// depends on sdf_pkg and the core; a built-in formatter predicts every character beat
`timescale 1ns / 100ps

module signed_decimal_formatter_core_tb;

  localparam int HALF_PERIOD    = 4;
  localparam int RESET_CYCLES   = 11;
  localparam int MAX_FIELD      = 63;
  localparam int LONG_HOLD      = 400;
  localparam int END_WAIT       = 200;
  localparam int WATCHDOG_LIMIT = 4000;
  localparam int RX_PHASE_LEN   = 113;

  localparam logic [3:0] F_NONE  = 4'b0000;
  localparam logic [3:0] F_LEFT  = 4'(1 << sdf_pkg::OPT_LEFT_JUST);
  localparam logic [3:0] F_ZERO  = 4'(1 << sdf_pkg::OPT_ZERO_PAD);
  localparam logic [3:0] F_PLUS  = 4'(1 << sdf_pkg::OPT_PLUS_SIGN);
  localparam logic [3:0] F_SPACE = 4'(1 << sdf_pkg::OPT_SPACE_SIGN);

  localparam logic [63:0] VAL_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] VAL_MIN = 64'h8000_0000_0000_0000;

  // receiver stall patterns
  typedef enum int {
    RX_STEADY,
    RX_COIN,
    RX_COMB
  } rx_mode_e;

  typedef struct {
    logic [63:0] value;
    logic [5:0]  field_width;
    logic        has_precision;
    logic [5:0]  min_digits;
    logic [3:0]  flag_bits;
    logic [7:0]  room;
  } fmt_req_t;

  typedef struct {
    logic [7:0] character;
    logic       last;
    logic       no_room;
  } char_beat_t;

  logic        clk_i;
  logic        rst_ni;
  logic [63:0] value_i;
  logic [5:0]  field_width_i;
  logic        has_precision_i;
  logic [5:0]  min_digits_i;
  logic [3:0]  flag_bits_i;
  logic [7:0]  room_i;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [7:0]  character_o;
  logic        last_o;
  logic        no_room_o;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;

  char_beat_t  field_chars_q[$];
  char_beat_t  got_beat;
  int unsigned err_count = 0;
  int unsigned beat_no = 0;
  int unsigned burst_left;
  int unsigned hold_req_cnt;
  int unsigned hold_seen = 0;
  int unsigned hold_left = 0;
  int unsigned rx_tick = 0;
  rx_mode_e    rx_mode;
  int unsigned stall_cycles = 0;

  signed_decimal_formatter_core DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .value_i        (value_i),
    .field_width_i  (field_width_i),
    .has_precision_i(has_precision_i),
    .min_digits_i   (min_digits_i),
    .flag_bits_i    (flag_bits_i),
    .room_i         (room_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .character_o    (character_o),
    .last_o         (last_o),
    .no_room_o      (no_room_o),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i)
  );

  initial clk_i = 1'b0;
  always #(HALF_PERIOD) clk_i = ~clk_i;

  task automatic report_mismatch(input string msg);
    $display("ERROR at %0t ns, beat %0d: %s", $time, beat_no, msg);
    err_count++;
  endtask

  // expected character beats of one formatted field
  function automatic void format_field(input fmt_req_t r);
    logic [63:0] mag;
    logic [7:0]  digs[0:23];
    logic [7:0]  text[$];
    logic [7:0]  sign_ch;
    int          nd;
    int          width;
    int          prec;
    int          sign_len;
    int          ndig;
    int          nlen;
    int          total;
    int          i;
    char_beat_t  b;
    mag   = r.value[63] ? (~r.value + 64'd1) : r.value;
    width = (r.field_width > MAX_FIELD) ? MAX_FIELD : int'(r.field_width);
    prec  = (r.min_digits > MAX_FIELD) ? MAX_FIELD : int'(r.min_digits);
    nd = 0;
    do begin
      digs[nd] = sdf_pkg::CHAR_ZERO + 8'(mag % 64'd10);
      mag = mag / 64'd10;
      nd++;
    end while (mag != 64'd0 && nd < 24);
    if (r.value[63]) begin
      sign_ch = sdf_pkg::CHAR_MINUS;
    end else if (r.flag_bits[sdf_pkg::OPT_PLUS_SIGN]) begin
      sign_ch = sdf_pkg::CHAR_PLUS;
    end else if (r.flag_bits[sdf_pkg::OPT_SPACE_SIGN]) begin
      sign_ch = sdf_pkg::CHAR_SPACE;
    end else begin
      sign_ch = sdf_pkg::CHAR_NUL;
    end
    sign_len = (sign_ch != sdf_pkg::CHAR_NUL) ? 1 : 0;
    ndig = nd;
    if (r.has_precision) begin
      if (prec > ndig) ndig = prec;
    end else if (r.flag_bits[sdf_pkg::OPT_ZERO_PAD] && !r.flag_bits[sdf_pkg::OPT_LEFT_JUST]) begin
      // zero fill counts the sign inside the width
      if (width > sign_len && width - sign_len > ndig) ndig = width - sign_len;
    end
    nlen  = sign_len + ndig;
    total = (width > nlen) ? width : nlen;
    if (total + 1 > int'(r.room) || total == 0) begin
      b = '{character: sdf_pkg::CHAR_NUL, last: 1'b1, no_room: 1'b1};
      field_chars_q.push_back(b);
      return;
    end
    if (!r.flag_bits[sdf_pkg::OPT_LEFT_JUST]) begin
      for (i = nlen; i < total; i++) text.push_back(sdf_pkg::CHAR_SPACE);
    end
    if (sign_len != 0) text.push_back(sign_ch);
    for (i = nd; i < ndig; i++) text.push_back(sdf_pkg::CHAR_ZERO);
    for (i = nd; i > 0; i--) text.push_back(digs[i-1]);
    if (r.flag_bits[sdf_pkg::OPT_LEFT_JUST]) begin
      for (i = nlen; i < total; i++) text.push_back(sdf_pkg::CHAR_SPACE);
    end
    foreach (text[k]) begin
      b = '{character: text[k], last: (k == text.size() - 1), no_room: 1'b0};
      field_chars_q.push_back(b);
    end
  endfunction

  function automatic fmt_req_t mk_req(input logic [63:0] v, input int w, input bit hp,
                                      input int p, input logic [3:0] f, input int rm);
    fmt_req_t r;
    r.value         = v;
    r.field_width   = 6'(w);
    r.has_precision = hp;
    r.min_digits    = 6'(p);
    r.flag_bits     = f;
    r.room          = 8'(rm);
    return r;
  endfunction

  function automatic logic [63:0] rand_value();
    logic [63:0] v;
    int          k;
    case ($urandom_range(0, 5))
      0: v = 64'($urandom_range(0, 999));
      1: v = {$urandom(), $urandom()};
      2: begin
        case ($urandom_range(0, 5))
          0: v = VAL_MAX;
          1: v = VAL_MIN;
          2: v = 64'd0;
          3: v = '1;
          4: v = 64'd1;
          default: v = VAL_MIN + 64'd1;
        endcase
      end
      3: begin
        // decade boundaries: 10^k and 10^k - 1
        k = $urandom_range(0, 18);
        v = 64'd1;
        repeat (k) v = v * 64'd10;
        v = v - 64'($urandom_range(0, 1));
      end
      default: v = {$urandom(), $urandom()} >> $urandom_range(1, 62);
    endcase
    if ($urandom_range(0, 1) == 1) v = -v;
    return v;
  endfunction

  function automatic fmt_req_t rand_req();
    fmt_req_t r;
    r.value = rand_value();
    r.field_width = ($urandom_range(0, 9) < 7) ? 6'($urandom_range(0, 12))
                                               : 6'($urandom_range(0, 63));
    r.has_precision = 1'($urandom_range(0, 1));
    r.min_digits = ($urandom_range(0, 9) < 7) ? 6'($urandom_range(0, 12))
                                              : 6'($urandom_range(0, 63));
    r.flag_bits = 4'($urandom_range(0, 15));
    // mostly enough room, sometimes tight enough to overflow
    r.room = ($urandom_range(0, 9) < 6) ? 8'($urandom_range(65, 255))
                                        : 8'($urandom_range(0, 30));
    return r;
  endfunction

  // called at a rising edge; returns at the edge where the beat is taken
  task automatic send_item(input fmt_req_t r);
    value_i         <= r.value;
    field_width_i   <= r.field_width;
    has_precision_i <= r.has_precision;
    min_digits_i    <= r.min_digits;
    flag_bits_i     <= r.flag_bits;
    room_i          <= r.room;
    in_valid_i      <= 1'b1;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    format_field(r);
  endtask

  // bursts of random length with random gaps between them
  task automatic sender_pace();
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(20, 150)) @(posedge clk_i);
      end else begin
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? 30 : $urandom_range(1, 8);
    end
  endtask

  task automatic test_directed();
    fmt_req_t reqs[$];
    reqs.push_back(mk_req(64'd0, 0, 0, 0, F_NONE, 255));
    reqs.push_back(mk_req(64'd0, 0, 1, 0, F_NONE, 255));
    reqs.push_back(mk_req(VAL_MAX, 0, 0, 0, F_NONE, 255));
    reqs.push_back(mk_req(VAL_MIN, 0, 0, 0, F_NONE, 255));
    reqs.push_back(mk_req(-64'sd1, 5, 0, 0, F_NONE, 255));
    reqs.push_back(mk_req(64'd42, 0, 0, 0, F_PLUS, 255));
    reqs.push_back(mk_req(64'd42, 0, 0, 0, F_SPACE, 255));
    reqs.push_back(mk_req(64'd42, 0, 0, 0, F_PLUS | F_SPACE, 255));
    reqs.push_back(mk_req(-64'sd42, 0, 0, 0, F_SPACE, 255));
    reqs.push_back(mk_req(64'd42, 8, 0, 0, F_ZERO | F_PLUS, 255));
    reqs.push_back(mk_req(-64'sd42, 8, 0, 0, F_ZERO, 255));
    reqs.push_back(mk_req(64'd42, 8, 0, 0, F_ZERO | F_LEFT, 255));
    reqs.push_back(mk_req(-64'sd42, 10, 1, 5, F_LEFT, 255));
    reqs.push_back(mk_req(64'd7, 6, 1, 3, F_ZERO, 255));
    reqs.push_back(mk_req(64'd0, 4, 0, 0, F_SPACE | F_ZERO, 255));
    reqs.push_back(mk_req(VAL_MIN, 0, 1, 63, F_NONE, 255));
    reqs.push_back(mk_req(64'd123, 63, 0, 0, F_LEFT | F_PLUS, 255));
    reqs.push_back(mk_req(64'd123, 0, 0, 0, F_NONE, 0));
    reqs.push_back(mk_req(64'd123, 5, 0, 0, F_NONE, 6));
    reqs.push_back(mk_req(64'd123, 5, 0, 0, F_NONE, 5));
    reqs.push_back(mk_req(-64'sd5, 0, 0, 0, F_NONE, 2));
    reqs.push_back(mk_req(-64'sd5, 0, 0, 0, F_NONE, 3));
    reqs.push_back(mk_req(64'd0, 63, 0, 0, F_ZERO | F_PLUS, 64));
    reqs.push_back(mk_req('1, 63, 1, 63, 4'hF, 255));
    foreach (reqs[i]) begin
      send_item(reqs[i]);
      sender_pace();
    end
  endtask

  task automatic test_random_formats(input int count);
    repeat (count) begin
      send_item(rand_req());
      sender_pace();
    end
  endtask

  // receiver holds off while the sender keeps offering: input side must stall
  task automatic test_output_backpressure();
    hold_req_cnt <= hold_req_cnt + 1;
    repeat (12) send_item(rand_req());
    sender_pace();
  endtask

  // sender goes quiet until every expected beat is back, then resumes
  task automatic test_drain_pause();
    in_valid_i <= 1'b0;
    while (field_chars_q.size() != 0) @(posedge clk_i);
    repeat (14) begin
      send_item(rand_req());
      sender_pace();
    end
  endtask

  // receiver: rotating stall pattern plus requested long hold-offs
  always @(posedge clk_i) begin
    if (hold_seen != hold_req_cnt) begin
      hold_seen = hold_req_cnt;
      hold_left = LONG_HOLD;
    end
    rx_tick++;
    rx_mode = rx_mode_e'((rx_tick / RX_PHASE_LEN) % 3);
    if (hold_left > 0) begin
      hold_left--;
      out_ready_i <= 1'b0;
    end else begin
      case (rx_mode)
        RX_STEADY: out_ready_i <= 1'b1;
        RX_COIN:   out_ready_i <= 1'($urandom_range(0, 1));
        default:   out_ready_i <= ((rx_tick % 5) >= 2);
      endcase
    end
  end

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_ready_i) begin
      if (field_chars_q.size() == 0) begin
        report_mismatch($sformatf("unexpected beat char=%02h last=%0b no_room=%0b",
                                  character_o, last_o, no_room_o));
      end else begin
        got_beat = field_chars_q.pop_front();
        if (character_o !== got_beat.character)
          report_mismatch($sformatf("character %02h, wanted %02h",
                                    character_o, got_beat.character));
        if (last_o !== got_beat.last)
          report_mismatch($sformatf("last %0b, wanted %0b", last_o, got_beat.last));
        if (no_room_o !== got_beat.no_room)
          report_mismatch($sformatf("no_room %0b, wanted %0b", no_room_o, got_beat.no_room));
      end
      beat_no++;
    end
  end

  // watchdog on cycles with no beat on either channel
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no beat for %0d cycles, %0d beats outstanding",
               stall_cycles, field_chars_q.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  initial begin
    rst_ni          = 1'b0;
    value_i         = '0;
    field_width_i   = '0;
    has_precision_i = 1'b0;
    min_digits_i    = '0;
    flag_bits_i     = '0;
    room_i          = '0;
    in_valid_i      = 1'b0;
    burst_left      = 4;
    hold_req_cnt    = 0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_random_formats(110);
    test_output_backpressure();
    test_random_formats(120);
    test_drain_pause();

    in_valid_i <= 1'b0;
    while (field_chars_q.size() != 0) @(posedge clk_i);
    repeat (END_WAIT) @(posedge clk_i);
    if (err_count == 0 && field_chars_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
